// File: rtl/chbd_pkg.sv
`default_nettype none

package chbd_pkg;

	// Default width of the chunk size counter.
	localparam int SIZE_BITS_DEF = 32;

	// Characters that steer the parser.
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_HT    = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;

	// Bits taken by one hex digit.
	localparam int DIGIT_BITS = 4;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_SIZE  = 3'd1,
		PH_DATA  = 3'd2,
		PH_DCR   = 3'd3,
		PH_DLF   = 3'd4,
		PH_TRAIL = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		SP_LEAD   = 2'd0,
		SP_DIGITS = 2'd1,
		SP_TRAIL  = 2'd2,
		SP_EXT    = 2'd3
	} subphase_t;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_DONE = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ERR_SIZE_LINE = 2'd0,
		ERR_TERM      = 2'd1,
		ERR_TRAILER   = 2'd2,
		ERR_OVERFLOW  = 2'd3
	} err_t;

	// Parser control state, apart from the size counter.
	typedef struct packed {
		phase_t    phase;
		subphase_t sub;
		logic      cr_pending;
		logic      line_has_content;
		logic      colon_seen;
	} ctrl_t;

	// One result beat.
	typedef struct packed {
		kind_t      kind;
		logic [7:0] payload_byte;
		err_t       error_code;
	} result_t;

	// Hex digit test and value.
	function automatic logic is_hex(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
			(c >= 8'h41 && c <= 8'h46);
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] v;
		if (c <= 8'h39) begin
			v = c - 8'h30;
		end else if (c >= 8'h61) begin
			v = c - 8'h57;
		end else begin
			v = c - 8'h37;
		end
		return v[3:0];
	endfunction

	function automatic logic is_ws(input logic [7:0] c);
		return c == CH_SP || c == CH_HT || c == CH_VT || c == CH_FF || c == CH_CR ||
			c == CH_LF;
	endfunction

endpackage

`default_nettype wire

// File: rtl/chbd_if.sv
`default_nettype none

// Raw body byte channel.
interface chbd_body_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       start_message;

	modport source (output valid, output data_byte, output start_message, input ready);
	modport sink (input valid, input data_byte, input start_message, output ready);
	modport mon (input valid, input data_byte, input start_message, input ready);
endinterface

// Decoded result channel.
interface chbd_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] payload_byte;
	logic [1:0] error_code;

	modport source (output valid, output kind, output payload_byte, output error_code,
		input ready);
	modport sink (input valid, input kind, input payload_byte, input error_code,
		output ready);
	modport mon (input valid, input kind, input payload_byte, input error_code,
		input ready);
endinterface

`default_nettype wire

// File: rtl/chbd_step.sv
`default_nettype none

// Next-state and result logic for one body byte.
module chbd_step import chbd_pkg::*; #(
	parameter int SIZE_BITS = SIZE_BITS_DEF
) (
	input  wire ctrl_t                ctrl,
	input  wire logic [SIZE_BITS-1:0] rem,
	input  wire logic [7:0]           data_byte,
	input  wire logic                 start_message,
	output ctrl_t                     ctrl_nxt,
	output logic [SIZE_BITS-1:0]      rem_nxt,
	output logic                      res_valid,
	output result_t                   res
);

	ctrl_t                c0;
	logic [SIZE_BITS-1:0] r0;
	logic                 line_end;
	logic                 fail;
	err_t                 fail_code;

	always_comb begin
		// A start beat opens a fresh size line before the byte is parsed.
		c0 = ctrl;
		r0 = rem;
		if (start_message) begin
			c0.phase            = PH_SIZE;
			c0.sub              = SP_LEAD;
			c0.cr_pending       = 1'b0;
			c0.line_has_content = 1'b0;
			c0.colon_seen       = 1'b0;
			r0                  = '0;
		end

		ctrl_nxt  = c0;
		rem_nxt   = r0;
		res_valid = 1'b0;
		res       = '{kind: KIND_DATA, payload_byte: 8'h00, error_code: ERR_SIZE_LINE};
		fail      = 1'b0;
		fail_code = ERR_SIZE_LINE;
		line_end  = c0.cr_pending && data_byte == CH_LF;

		unique case (c0.phase)
			PH_SIZE: begin
				if (line_end) begin
					if (!c0.line_has_content) begin
						fail = 1'b1;
					end else begin
						ctrl_nxt.phase            = (r0 == '0) ? PH_TRAIL : PH_DATA;
						ctrl_nxt.sub              = SP_LEAD;
						ctrl_nxt.cr_pending       = 1'b0;
						ctrl_nxt.line_has_content = 1'b0;
						ctrl_nxt.colon_seen       = 1'b0;
					end
				end else begin
					ctrl_nxt.cr_pending = (data_byte == CH_CR);
					if (c0.sub == SP_EXT) begin
						// Extension text is skipped up to the line end.
					end else if (data_byte == CH_SEMI) begin
						ctrl_nxt.sub = SP_EXT;
					end else if (is_ws(data_byte)) begin
						if (c0.sub == SP_DIGITS) begin
							ctrl_nxt.sub = SP_TRAIL;
						end
					end else if (!is_hex(data_byte) || c0.sub == SP_TRAIL) begin
						fail = 1'b1;
					end else if (r0[SIZE_BITS-1 -: DIGIT_BITS] != '0) begin
						fail      = 1'b1;
						fail_code = ERR_OVERFLOW;
					end else begin
						rem_nxt = {r0[SIZE_BITS-DIGIT_BITS-1:0], hex_val(data_byte)};
						ctrl_nxt.sub              = SP_DIGITS;
						ctrl_nxt.line_has_content = 1'b1;
					end
				end
			end
			PH_DATA: begin
				// Payload byte passes through; the counter says when it ends.
				rem_nxt   = r0 - SIZE_BITS'(1);
				res_valid = 1'b1;
				res.payload_byte = data_byte;
				if (r0 == SIZE_BITS'(1)) begin
					ctrl_nxt.phase = PH_DCR;
				end
			end
			PH_DCR: begin
				if (data_byte != CH_CR) begin
					fail      = 1'b1;
					fail_code = ERR_TERM;
				end else begin
					ctrl_nxt.phase = PH_DLF;
				end
			end
			PH_DLF: begin
				if (data_byte != CH_LF) begin
					fail      = 1'b1;
					fail_code = ERR_TERM;
				end else begin
					ctrl_nxt.phase            = PH_SIZE;
					ctrl_nxt.sub              = SP_LEAD;
					ctrl_nxt.cr_pending       = 1'b0;
					ctrl_nxt.line_has_content = 1'b0;
					ctrl_nxt.colon_seen       = 1'b0;
					rem_nxt                   = '0;
				end
			end
			PH_TRAIL: begin
				if (line_end) begin
					ctrl_nxt.sub              = SP_LEAD;
					ctrl_nxt.cr_pending       = 1'b0;
					ctrl_nxt.line_has_content = 1'b0;
					ctrl_nxt.colon_seen       = 1'b0;
					if (!c0.line_has_content) begin
						// An empty trailer line closes the message.
						ctrl_nxt.phase = PH_IDLE;
						res_valid      = 1'b1;
						res.kind       = KIND_DONE;
					end else if (!c0.colon_seen) begin
						fail      = 1'b1;
						fail_code = ERR_TRAILER;
					end
				end else begin
					if (c0.cr_pending) begin
						ctrl_nxt.line_has_content = 1'b1;
					end
					if (data_byte == CH_CR) begin
						ctrl_nxt.cr_pending = 1'b1;
					end else begin
						ctrl_nxt.cr_pending       = 1'b0;
						ctrl_nxt.line_has_content = 1'b1;
						if (data_byte == CH_COLON) begin
							ctrl_nxt.colon_seen = 1'b1;
						end
					end
				end
			end
			default: begin
				// Idle: bytes are dropped until the next start.
			end
		endcase

		// Any error parks the parser and clears the counter.
		if (fail) begin
			ctrl_nxt.phase            = PH_IDLE;
			ctrl_nxt.sub              = SP_LEAD;
			ctrl_nxt.cr_pending       = 1'b0;
			ctrl_nxt.line_has_content = 1'b0;
			ctrl_nxt.colon_seen       = 1'b0;
			rem_nxt                   = '0;
			res_valid                 = 1'b1;
			res.kind                  = KIND_ERR;
			res.payload_byte          = 8'h00;
			res.error_code            = fail_code;
		end
	end

endmodule

`default_nettype wire

// File: rtl/chbd_out_queue.sv
`default_nettype none

// Two-entry result queue that lets the parser run while a result waits.
module chbd_out_queue import chbd_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire result_t push_data,
	output logic         full,
	chbd_result_if.source result
);

	result_t    entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;
	result_t    head;

	assign pop  = result.valid && result.ready;
	assign full = (count_q == 2'd2);
	assign head = entry_q[rd_ptr_q];

	assign result.valid        = (count_q != 2'd0);
	assign result.kind         = head.kind;
	assign result.payload_byte = head.payload_byte;
	assign result.error_code   = head.error_code;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// File: rtl/http_chunked_body_decoder_unit.sv
`default_nettype none

// Channel  Dir  Beat content
// body     in   data_byte, start_message
// result   out  kind, payload_byte, error_code
//
// While body.ready is high one body beat is taken per cycle; its result, if any,
// is in the output queue the next cycle. The parser state registers and the combinational
// byte step set that figure. A two-entry output queue keeps body.ready high while one
// result waits; body.ready drops only when two results wait.
// Reset puts the parser in idle, where bytes give no result until a start beat.
module http_chunked_body_decoder_unit import chbd_pkg::*; #(
	parameter int SIZE_BITS = SIZE_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	chbd_body_if.sink     body,
	chbd_result_if.source result
);

	ctrl_t                ctrl_q;
	logic [SIZE_BITS-1:0] rem_q;
	ctrl_t                ctrl_nxt;
	logic [SIZE_BITS-1:0] rem_nxt;
	logic                 res_valid;
	result_t              res;
	logic                 full;
	logic                 accept;

	assign body.ready = !full;
	assign accept     = body.valid && body.ready;

	chbd_step #(
		.SIZE_BITS(SIZE_BITS)
	) u_step (
		.ctrl         (ctrl_q),
		.rem          (rem_q),
		.data_byte    (body.data_byte),
		.start_message(body.start_message),
		.ctrl_nxt     (ctrl_nxt),
		.rem_nxt      (rem_nxt),
		.res_valid    (res_valid),
		.res          (res)
	);

	// Parser state advances on every accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '{phase: PH_IDLE, sub: SP_LEAD, cr_pending: 1'b0,
				line_has_content: 1'b0, colon_seen: 1'b0};
			rem_q  <= '0;
		end else if (accept) begin
			ctrl_q <= ctrl_nxt;
			rem_q  <= rem_nxt;
		end
	end

	chbd_out_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept && res_valid),
		.push_data(res),
		.full     (full),
		.result   (result)
	);

endmodule

`default_nettype wire

// File: rtl/chbd_checker.sv
`default_nettype none

// Port-level checks on the decoder.
module chbd_checker import chbd_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       body_ready,
	input wire logic       result_valid,
	input wire logic       result_ready,
	input wire logic [1:0] result_kind,
	input wire logic [7:0] result_payload_byte,
	input wire logic [1:0] result_error_code
);

	// A stalled result beat stays put.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_kind) &&
		$stable(result_payload_byte) && $stable(result_error_code))
		else $error("result beat changed while stalled");

	// Body back-pressure only happens while results are waiting.
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!body_ready |-> result_valid)
		else $error("body stalled with no result pending");

	// The kind is one of the three defined codes.
	a_kind_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result_kind != 2'd3)
		else $error("undefined result kind");

	// Non-data results carry a zero payload byte.
	a_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_kind != KIND_DATA |-> result_payload_byte == 8'h00)
		else $error("payload byte set on a non-data result");

	// Non-error results carry a zero error code.
	a_code_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_kind != KIND_ERR |-> result_error_code == ERR_SIZE_LINE)
		else $error("error code set on a non-error result");

endmodule

bind http_chunked_body_decoder_unit chbd_checker u_chbd_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.body_ready         (body.ready),
	.result_valid       (result.valid),
	.result_ready       (result.ready),
	.result_kind        (result.kind),
	.result_payload_byte(result.payload_byte),
	.result_error_code  (result.error_code)
);

`default_nettype wire
